// ===== sv/deq_pkg.sv =====
package deq_pkg;

  // Command codes carried in the input item.
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_PEEK       = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] removed_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
  } deq_out_t;

endpackage

// ===== sv/deq_ram.sv =====
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit words kept in a ring of DEPTH slots.
// Input channel (in_valid/in_ready/in_data) takes one command per transfer: push at
// the rear or front, pop from the front or rear, or peek. Every command gives exactly
// one result transfer on out_valid/out_ready/out_data with a status, the removed word,
// the front and rear words after the command, an empty flag and the word count.
// A pop on an empty queue reports an empty error and a push on a full queue reports a
// full error; neither changes the contents. Front and rear read as zero when empty.
// The front and rear words are cached in registers, so pushes, peeks, errors and pops
// that leave at most one word have the result registered at the edge that takes the
// command. A pop that leaves two or more words first fetches the new end word through
// the registered read port of the slot RAM; no new command is taken during that fetch.
// Throughput is thus one command per cycle while no fetch is pending and results leave.
// Synchronous reset empties the queue; slot contents are not cleared.
// The result register decouples the two sides: a new command is taken while the
// previous result is being taken. If the receiver stalls, the result holds and no
// further command is taken until it leaves.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_out_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [PTR_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [WORD_W-1:0]  front_r, front_nxt;
  logic signed [WORD_W-1:0]  rear_r, rear_nxt;
  logic signed [WORD_W-1:0]  rem_r, rem_nxt;
  logic                      fetch_front_r, fetch_front_nxt;
  logic                      out_valid_r, out_valid_nxt;
  deq_out_t                  out_data_r, out_data_nxt;

  logic                      accept;
  logic                      load_out;
  logic                      is_full;
  logic                      is_zero;
  logic [1:0]                status;
  logic signed [WORD_W-1:0]  removed;
  logic [PTR_W-1:0]          head_inc, head_dec, tail_inc, tail_dec;
  deq_out_t                  res;

  logic                      wr_en, rd_en;
  logic [PTR_W-1:0]          wr_addr, rd_addr;
  logic [WORD_W-1:0]         wr_data, rd_data;

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A command is taken only when no fetch is pending and the result register frees up.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Ring pointer steps with wrap at the last slot. The tail sits one slot
  // behind the head when the queue is empty.
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + PTR_W'(1);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - PTR_W'(1);
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + PTR_W'(1);
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - PTR_W'(1);

  assign is_full = (count_r == FULL_CNT);
  assign is_zero = (count_r == '0);

  // Command decode, cached end words and slot RAM control.
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    rem_nxt         = rem_r;
    fetch_front_nxt = fetch_front_r;
    status          = STAT_OK;
    removed         = '0;
    load_out        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = tail_inc;
    wr_data         = in_data.value;
    rd_en           = 1'b0;
    rd_addr         = head_inc;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_data.command)
            CMD_PUSH_REAR: begin
              if (is_full) begin
                status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = tail_inc;
                tail_nxt  = tail_inc;
                count_nxt = count_r + ONE_CNT;
                rear_nxt  = in_data.value;
                if (is_zero) begin
                  front_nxt = in_data.value;
                end
              end
            end
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + ONE_CNT;
                front_nxt = in_data.value;
                if (is_zero) begin
                  rear_nxt = in_data.value;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (is_zero) begin
                status = STAT_EMPTY;
              end else begin
                removed   = front_r;
                head_nxt  = head_inc;
                count_nxt = count_r - ONE_CNT;
                if (count_r == ONE_CNT) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                end else if (count_r == TWO_CNT) begin
                  front_nxt = rear_r;
                end else begin
                  // The new front word has to come from the RAM.
                  rd_en           = 1'b1;
                  rd_addr         = head_inc;
                  rem_nxt         = front_r;
                  fetch_front_nxt = 1'b1;
                  load_out        = 1'b0;
                  state_nxt       = ST_FETCH;
                end
              end
            end
            CMD_POP_REAR: begin
              if (is_zero) begin
                status = STAT_EMPTY;
              end else begin
                removed   = rear_r;
                tail_nxt  = tail_dec;
                count_nxt = count_r - ONE_CNT;
                if (count_r == ONE_CNT) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                end else if (count_r == TWO_CNT) begin
                  rear_nxt = front_r;
                end else begin
                  // The new rear word has to come from the RAM.
                  rd_en           = 1'b1;
                  rd_addr         = tail_dec;
                  rem_nxt         = rear_r;
                  fetch_front_nxt = 1'b0;
                  load_out        = 1'b0;
                  state_nxt       = ST_FETCH;
                end
              end
            end
            CMD_PEEK: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Read data for the new end word is available now.
        load_out  = 1'b1;
        removed   = rem_r;
        state_nxt = ST_IDLE;
        if (fetch_front_r) begin
          front_nxt = rd_data;
        end else begin
          rear_nxt = rd_data;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.status        = status;
    res.removed_value = removed;
    res.front_value   = front_nxt;
    res.rear_value    = rear_nxt;
    res.is_empty      = (count_nxt == '0);
    res.occupancy     = OCC_W'(count_nxt);

    out_valid_nxt = load_out || (out_valid_r && !out_ready);
    out_data_nxt  = load_out ? res : out_data_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= LAST_IDX;
      count_r     <= '0;
      front_r     <= '0;
      rear_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    fetch_front_r <= fetch_front_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The word count never passes the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("word count exceeds ring size");

  // A RAM fetch always completes in the following cycle.
  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |=> state_r == ST_IDLE)
    else $error("fetch state lasted more than one cycle");

  // The result register is free whenever fetched data must be reported.
  a_fetch_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |-> !out_valid_r)
    else $error("result register busy during fetch");

  // An empty queue keeps zero in both cached end words.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0) && (rear_r == '0))
    else $error("cached end word not zero while empty");

  // A fetch is only started by a pop that leaves at least two words.
  a_fetch_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && (state_nxt == ST_FETCH) |=> count_r >= TWO_CNT)
    else $error("fetch started with fewer than two words left");

endmodule

// ===== verif/double_ended_queue_unit_tb.sv =====
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 920;
  localparam int HOLD_CYCLES  = 64;
  localparam int MAX_PRINTED  = 200;

  // Tracks the queue contents and checks every result transfer in order.
  class deq_scoreboard;
    logic signed [WORD_W-1:0] ring [DEPTH];
    logic [3:0]               front_idx;
    logic [OCC_W-1:0]         words_held;
    deq_out_t                 awaited_results [$];
    int                       errors;

    function new();
      front_idx  = '0;
      words_held = '0;
      errors     = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endtask

    // Apply one command to the tracked contents and return the result it gives.
    function deq_out_t apply_command(input deq_in_t cmd_item);
      deq_out_t   res;
      logic [3:0] idx;
      res = '0;
      case (cmd_item.command)
        CMD_PUSH_REAR: begin
          if (words_held == OCC_W'(DEPTH)) begin
            res.status = STAT_FULL;
          end else begin
            idx = front_idx + words_held[3:0];
            ring[idx] = cmd_item.value;
            words_held++;
          end
        end
        CMD_PUSH_FRONT: begin
          if (words_held == OCC_W'(DEPTH)) begin
            res.status = STAT_FULL;
          end else begin
            front_idx = front_idx - 4'd1;
            ring[front_idx] = cmd_item.value;
            words_held++;
          end
        end
        CMD_POP_FRONT: begin
          if (words_held == '0) begin
            res.status = STAT_EMPTY;
          end else begin
            res.removed_value = ring[front_idx];
            front_idx = front_idx + 4'd1;
            words_held--;
          end
        end
        CMD_POP_REAR: begin
          if (words_held == '0) begin
            res.status = STAT_EMPTY;
          end else begin
            idx = front_idx + words_held[3:0] - 4'd1;
            res.removed_value = ring[idx];
            words_held--;
          end
        end
        default: begin
          // Peek and the unused codes leave the contents alone.
        end
      endcase
      if (words_held != '0) begin
        idx = front_idx + words_held[3:0] - 4'd1;
        res.front_value = ring[front_idx];
        res.rear_value  = ring[idx];
      end
      res.is_empty  = (words_held == '0);
      res.occupancy = words_held;
      return res;
    endfunction

    function void note_command(input deq_in_t cmd_item);
      awaited_results.push_back(apply_command(cmd_item));
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    task check_result(input deq_out_t got);
      deq_out_t want;
      if (awaited_results.size() == 0) begin
        report("result transfer with no command outstanding");
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.removed_value !== want.removed_value)
        report($sformatf("removed_value got %0d want %0d",
                         got.removed_value, want.removed_value));
      if (got.front_value !== want.front_value)
        report($sformatf("front_value got %0d want %0d", got.front_value, want.front_value));
      if (got.rear_value !== want.rear_value)
        report($sformatf("rear_value got %0d want %0d", got.rear_value, want.rear_value));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty got %0d want %0d", got.is_empty, want.is_empty));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  deq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  deq_out_t out_data;

  deq_scoreboard sb = new();

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Observe both channels at the rising edge; results are checked before the
  // command taken at the same edge is noted, since they belong to older commands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_command(in_data);
    end
  end

  // Offer one command and hold it until the transfer happens.
  task automatic send_command(input logic [2:0] cmd, input logic [WORD_W-1:0] val);
    @(negedge clk);
    in_data  <= '{command: cmd, value: val};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Extremes show up often so that every bit sees both values.
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Lean toward pushes, pops or neither so that the queue swings between
  // full and empty over the run.
  function automatic logic [2:0] pick_command(input int lean);
    int push_pct;
    int roll;
    push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 3'($urandom_range(5, 7));
    if (roll < 10) return CMD_PEEK;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  // Receiver: segments of steady, random and periodic readiness, with a long
  // hold-off now and then so that the result register backs up into the input.
  initial begin
    int seg;
    int mode;
    int len;
    out_ready = 1'b0;
    seg = 0;
    wait (rst_n);
    forever begin
      seg++;
      if (seg % 25 == 4) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 60);
        for (int c = 0; c < len; c++) begin
          @(negedge clk);
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 2) != 0);
            default: out_ready <= (c % 4 != 3);
          endcase
        end
      end
    end
  end

  // Sender: directed corner cases, then random bursts with gaps.
  initial begin
    int sent;
    int lean;
    int burst;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Commands on an empty queue, including the unused codes.
    send_command(CMD_PEEK, 32'h1234_5678);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '1);
    send_command(3'd5, 32'h8000_0000);
    send_command(3'd6, 32'h7fff_ffff);
    send_command(3'd7, '1);
    // Both ends with the extreme words.
    send_command(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PEEK, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    // Fill from both ends, then push into a full queue at each end.
    for (int i = 0; i < DEPTH; i++) begin
      send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
    end
    send_command(CMD_PUSH_REAR, 32'h5555_5555);
    send_command(CMD_PUSH_FRONT, 32'haaaa_aaaa);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      lean  = $urandom_range(0, 2);
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_command(pick_command(lean), pick_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
    pause_sender(1);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
